/* rtl/maco_pkg.sv */
// package: constants, tanh table and command/status types for the crossover oscillator
package maco_pkg;

	localparam int TanhSteps = 40;
	localparam int FracBits  = 16;
	localparam int SegBits   = 13;
	localparam int SatLimit  = 5;
	localparam logic [15:0] Q15Max = 16'd32767;

	typedef struct packed {
		logic start;
		logic win_full;
		logic out_busy;
	} maco_cmd_t;

	typedef struct packed {
		logic done;
	} maco_sts_t;

	function automatic logic [15:0] tanh_tab(input logic [5:0] k);
		logic [15:0] v;
		begin
			unique case (k)
				6'd0: v = 16'd0;      6'd1: v = 16'd4075;   6'd2: v = 16'd8025;
				6'd3: v = 16'd11742;  6'd4: v = 16'd15142;  6'd5: v = 16'd18173;
				6'd6: v = 16'd20812;  6'd7: v = 16'd23065;  6'd8: v = 16'd24955;
				6'd9: v = 16'd26518;  6'd10: v = 16'd27796; 6'd11: v = 16'd28829;
				6'd12: v = 16'd29659; 6'd13: v = 16'd30321; 6'd14: v = 16'd30846;
				6'd15: v = 16'd31261; 6'd16: v = 16'd31588; 6'd17: v = 16'd31845;
				6'd18: v = 16'd32047; 6'd19: v = 16'd32205; 6'd20: v = 16'd32328;
				6'd21: v = 16'd32425; 6'd22: v = 16'd32500; 6'd23: v = 16'd32559;
				6'd24: v = 16'd32605; 6'd25: v = 16'd32641; 6'd26: v = 16'd32669;
				6'd27: v = 16'd32690; 6'd28: v = 16'd32707; 6'd29: v = 16'd32720;
				6'd30: v = 16'd32731; 6'd31: v = 16'd32739; 6'd32: v = 16'd32745;
				6'd33: v = 16'd32750; 6'd34: v = 16'd32754; 6'd35: v = 16'd32757;
				6'd36: v = 16'd32759; 6'd37: v = 16'd32761; 6'd38: v = 16'd32762;
				6'd39: v = 16'd32763; 6'd40: v = 16'd32764;
				default: v = 16'd32764;
			endcase
			return v;
		end
	endfunction

endpackage

/* rtl/maco_ram.sv */
// generic single-port ram with registered read
module maco_ram #(
	parameter int Width = 16,
	parameter int Depth = 360
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

/* rtl/maco_datapath.sv */
// datapath: ring, running window sums, serial divider and tanh interpolation
module maco_datapath import maco_pkg::*; #(
	parameter int ShortLen    = 30,
	parameter int MidLen      = 120,
	parameter int LongLen     = 360,
	parameter int SampleWidth = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  maco_cmd_t        cmd,
	input  logic [15:0]      sample,
	output maco_sts_t        sts,
	output logic signed [15:0] indicator,
	output logic             zero_base
);
	localparam int Ls   = (ShortLen > LongLen) ? LongLen : ShortLen;
	localparam int Lm   = (MidLen > LongLen) ? LongLen : MidLen;
	localparam bit ShortAll = (Ls == LongLen);
	localparam bit MidAll   = (Lm == LongLen);
	localparam int AW   = $clog2(LongLen);
	localparam int SW   = SampleWidth + $clog2(LongLen) + 1;
	localparam int NW   = SW + $clog2(Lm + 1) + $clog2(LongLen + 1) + 2;
	localparam int DW   = SW + $clog2(Ls + 1) + $clog2(Lm + 1) + 1;
	localparam int QW   = 3 + FracBits;
	localparam int CW   = $clog2(QW + 1);
	localparam logic [AW-1:0] LastIdx = AW'(LongLen - 1);

	// phases of the per-sample sequence
	localparam logic [2:0] PhIdle = 3'd0;
	localparam logic [2:0] PhRdS  = 3'd1;
	localparam logic [2:0] PhRdM  = 3'd2;
	localparam logic [2:0] PhRdL  = 3'd3;
	localparam logic [2:0] PhUpd  = 3'd4;
	localparam logic [2:0] PhMul  = 3'd5;
	localparam logic [2:0] PhDiv  = 3'd6;
	localparam logic [2:0] PhOut  = 3'd7;

	logic [2:0]  ph_q;
	logic [1:0]  sub_q;
	logic [AW-1:0] wp_q;
	logic signed [SampleWidth-1:0] new_q, old_s_q, old_m_q, old_l_q;
	logic signed [SW-1:0] sum_s_q, sum_m_q, sum_l_q;
	logic full_q;
	logic signed [NW-1:0] num_q;
	logic signed [DW-1:0] den_q;
	logic [NW-1:0] rem_q;
	logic [DW-1:0] dmag_q;
	logic [QW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic neg_q;

	logic ram_we;
	logic [AW-1:0] ram_addr;
	logic [SampleWidth-1:0] ram_rd;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a, input int off);
		logic [AW:0] t;
		begin
			t = {1'b0, a} + (AW+1)'(off);
			if (t >= (AW+1)'(LongLen))
				t = t - (AW+1)'(LongLen);
			return t[AW-1:0];
		end
	endfunction

	// oldest sample sits at wp; the slot that enters a window sits len later
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = wp_q;
		case (ph_q)
			PhRdS: ram_addr = ring_add(wp_q, Ls % LongLen);
			PhRdM: ram_addr = ring_add(wp_q, Lm % LongLen);
			PhRdL: ram_addr = wp_q;
			PhUpd: begin
				ram_we   = 1'b1;
				ram_addr = wp_q;
			end
			default: ram_addr = wp_q;
		endcase
	end

	maco_ram #(.Width(SampleWidth), .Depth(LongLen)) u_ring (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(new_q),
		.rdata(ram_rd)
	);

	logic [NW-1:0] rem_sh;
	logic [NW-1:0] dmag_x;
	logic [15:0] ta, tb, tmag;
	logic [QW-1:0] u;
	logic [5:0] ti;
	logic [SegBits-1:0] tf;
	logic [15:0] tdiff;
	logic [31:0] tprod;

	always_comb begin
		dmag_x = NW'(dmag_q);
		rem_sh = {rem_q[NW-2:0], 1'b0};
		u      = quo_q;
		ti     = 6'(u >> SegBits);
		tf     = u[SegBits-1:0];
		ta     = tanh_tab(ti);
		tb     = tanh_tab(ti + 6'd1);
		tdiff  = tb - ta;
		tprod  = 32'(tdiff) * 32'(tf) + 32'(1 << (SegBits - 1));
		tmag   = ta + 16'(tprod >> SegBits);
		if (u[QW-1:FracBits] >= 3'(SatLimit) || ti >= 6'(TanhSteps))
			tmag = Q15Max;
	end

	// dependency: sums slide only after the ring is full, before that new samples add
	// (short and mid only while wp < len); sums track window [wp .. wp+len-1]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q    <= PhIdle;
			sub_q   <= '0;
			wp_q    <= '0;
			full_q  <= 1'b0;
			sum_s_q <= '0;
			sum_m_q <= '0;
			sum_l_q <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (ph_q)
				PhIdle: if (cmd.start) begin
					new_q <= sample[SampleWidth-1:0];
					full_q <= cmd.win_full;
					ph_q  <= PhRdS;
				end
				PhRdS: ph_q <= PhRdM;
				PhRdM: begin
					old_s_q <= ram_rd;
					ph_q    <= PhRdL;
				end
				PhRdL: begin
					old_m_q <= ram_rd;
					ph_q    <= PhUpd;
				end
				PhUpd: begin
					old_l_q <= ram_rd;
					ph_q    <= PhMul;
					sub_q   <= '0;
				end
				PhMul: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q == 2'd0) begin
						if (full_q) begin
							// a window as long as the ring takes in the new sample
							sum_s_q <= sum_s_q - SW'(old_l_q)
								+ (ShortAll ? SW'(new_q) : SW'(old_s_q));
							sum_m_q <= sum_m_q - SW'(old_l_q)
								+ (MidAll ? SW'(new_q) : SW'(old_m_q));
							sum_l_q <= sum_l_q - SW'(old_l_q) + SW'(new_q);
						end else begin
							sum_l_q <= sum_l_q + SW'(new_q);
							if ({1'b0, wp_q} < (AW+1)'(Ls))
								sum_s_q <= sum_s_q + SW'(new_q);
							if ({1'b0, wp_q} < (AW+1)'(Lm))
								sum_m_q <= sum_m_q + SW'(new_q);
						end
						wp_q <= (wp_q == LastIdx) ? '0 : wp_q + 1'b1;
					end else if (sub_q == 2'd1) begin
						num_q <= NW'(sum_s_q) * NW'(Lm) - NW'(sum_m_q) * NW'(Ls);
						den_q <= DW'(sum_l_q) * DW'(Ls * Lm);
					end else begin
						num_q <= num_q * NW'(LongLen);
						ph_q <= PhDiv;
						cnt_q <= '0;
					end
				end
				PhDiv: begin
					if (cnt_q == '0) begin
						neg_q  <= num_q[NW-1] ^ den_q[DW-1];
						rem_q  <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
						dmag_q <= den_q[DW-1] ? DW'(-den_q) : DW'(den_q);
						quo_q  <= '0;
						cnt_q  <= cnt_q + 1'b1;
					end else if (cnt_q == CW'(1)) begin
						// integer part by repeated subtraction, capped
						if (rem_q >= dmag_x && quo_q[2:0] < 3'(SatLimit)) begin
							rem_q <= rem_q - dmag_x;
							quo_q <= quo_q + 1'b1;
						end else begin
							quo_q <= quo_q << 1;
							cnt_q <= cnt_q + 1'b1;
						end
					end else if (rem_sh >= dmag_x) begin
						rem_q <= rem_sh - dmag_x;
						quo_q <= quo_q | QW'(1);
						if (cnt_q == CW'(FracBits + 1))
							ph_q <= PhOut;
						else begin
							quo_q <= (quo_q | QW'(1)) << 1;
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						rem_q <= rem_sh;
						if (cnt_q == CW'(FracBits + 1))
							ph_q <= PhOut;
						else begin
							quo_q <= quo_q << 1;
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// hold until the result register is free
				PhOut: if (!cmd.out_busy)
					ph_q <= PhIdle;
				default: ph_q <= PhIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ph_q == PhOut && !cmd.out_busy) begin
			zero_base <= (sum_l_q == '0);
			if (sum_l_q == '0 || num_q == '0)
				indicator <= '0;
			else
				indicator <= neg_q ? -$signed(tmag) : $signed(tmag);
		end
	end

	assign sts.done = (ph_q == PhOut) && !cmd.out_busy;
endmodule

/* rtl/maco_ctrl.sv */
// controller: input/output handshake and window fill tracking
module maco_ctrl import maco_pkg::*; #(
	parameter int LongLen = 360
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_ready,
	output logic      result_valid,
	input  logic      result_ready,
	output maco_cmd_t cmd,
	input  maco_sts_t sts
);
	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StBusy = 2'd1;
	localparam int FW = $clog2(LongLen + 1);

	logic [1:0] state_q;
	logic [FW-1:0] fill_q;
	logic out_q;

	// a new transaction may start while a result still waits; its result holds until that one leaves
	assign sample_ready = (state_q == StIdle);
	assign cmd.start    = sample_valid && sample_ready;
	assign cmd.win_full = (fill_q == FW'(LongLen));
	assign cmd.out_busy = out_q && !result_ready;
	assign result_valid = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			fill_q  <= '0;
			out_q   <= 1'b0;
		end else begin
			if (sts.done && fill_q >= FW'(LongLen - 1))
				out_q <= 1'b1;
			else if (result_ready)
				out_q <= 1'b0;
			unique case (state_q)
				StIdle: if (cmd.start)
					state_q <= StBusy;
				StBusy: if (sts.done) begin
					state_q <= StIdle;
					if (fill_q != FW'(LongLen))
						fill_q <= fill_q + 1'b1;
				end
				default: state_q <= StIdle;
			endcase
		end
	end
endmodule

/* rtl/moving_average_crossover_tanh_unit.sv */
// top level: moving-average crossover oscillator with tanh output
// per sample: ring reads, sum update, products, serial divide (integer part capped at 5),
// then tanh interpolation; the next sample is taken only once the last one is done
// a waiting result does not block the next sample, which holds at its last step instead
// reset: asynchronous active low; sums, pointer and fill count clear, the ring is not cleared
// no results for the first LONG_LEN - 1 samples
module moving_average_crossover_tanh_unit import maco_pkg::*; #(
	parameter int SHORT_LEN    = 30,
	parameter int MID_LEN      = 120,
	parameter int LONG_LEN     = 360,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_ready,
	input  logic signed [15:0] sample,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [15:0] indicator,
	output logic               zero_base
);
	maco_cmd_t cmd;
	maco_sts_t sts;

	maco_ctrl #(.LongLen(LONG_LEN)) u_ctrl (
		.clk, .arst_n, .sample_valid, .sample_ready,
		.result_valid, .result_ready, .cmd, .sts
	);

	maco_datapath #(
		.ShortLen(SHORT_LEN), .MidLen(MID_LEN),
		.LongLen(LONG_LEN), .SampleWidth(SAMPLE_WIDTH)
	) u_dp (
		.clk, .arst_n, .cmd, .sample, .sts, .indicator, .zero_base
	);

	a_zero_forces: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && zero_base |-> indicator == 16'sd0)
		else $error("zero base with nonzero indicator");
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> !sample_ready)
		else $error("second transaction taken while busy");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(indicator) && $stable(zero_base))
		else $error("pending result changed before it was taken");
endmodule
